[hdl/gwm_pkg.sv]
// Shared types, constants and helpers for the glob wildcard matcher.
// No dependencies; every other file in hdl/ imports this package.
package gwm_pkg;

  // Pattern capacity and fixed field widths
  localparam int unsigned MAX_PATTERN_BYTES = 32;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned CFG_DATA_W        = 64;
  localparam int unsigned CFG_ADDR_W        = 3;
  localparam int unsigned LEN_W             = 6;
  localparam int unsigned S_TDATA_W         = 8;
  localparam int unsigned M_TDATA_W         = 8;

  // Special bytes
  localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;
  localparam logic [BYTE_W-1:0] QMARK_BYTE = 8'h3F;
  localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;
  localparam logic [BYTE_W-1:0] UPPER_A    = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z    = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_BIT   = 8'h20;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PAT_WORD0 = 3'd0,
    CFG_PAT_WORD1 = 3'd1,
    CFG_PAT_WORD2 = 3'd2,
    CFG_PAT_WORD3 = 3'd3,
    CFG_PAT_LEN   = 3'd4,
    CFG_CASE_FOLD = 3'd5
  } gwm_cfg_e;

  // Signals handed from one cell to the next
  typedef struct packed {
    logic en;      // all pattern bytes up to here are in use
    logic spread;  // live star position also makes the next one live
    logic adv;     // live literal or '?' matched this subject byte
  } gwm_link_t;

  // Map 'A'..'Z' to lower case when folding is on
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                  input logic              fold_en);
    logic [BYTE_W-1:0] r;
    r = c;
    if (fold_en && (c >= UPPER_A) && (c <= UPPER_Z)) begin
      r = c | CASE_BIT;
    end
    return r;
  endfunction

endpackage

[hdl/gwm_cell.sv]
// One pattern position of the matcher row: holds its live bit and chains
// closure and advance terms to its neighbor. Depends on gwm_pkg.
module gwm_cell #(
  parameter bit StartCell = 1'b0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [gwm_pkg::BYTE_W-1:0] pat_byte_i,
  input  logic                      in_range_i,
  input  logic                      fold_i,
  input  logic [gwm_pkg::BYTE_W-1:0] subj_i,
  input  logic                      step_i,
  input  logic                      restart_i,
  input  gwm_pkg::gwm_link_t        link_i,
  output gwm_pkg::gwm_link_t        link_o,
  output logic                      end_hit_o
);
  import gwm_pkg::*;

  logic active_q, active_d;
  logic is_star, is_qmark, lit_hit, en, clos;

  // Decode this position's pattern byte
  assign is_star  = (pat_byte_i == STAR_BYTE);
  assign is_qmark = (pat_byte_i == QMARK_BYTE);
  assign lit_hit  = (fold_byte(pat_byte_i, fold_i) == fold_byte(subj_i, fold_i));
  assign en       = link_i.en & in_range_i & (pat_byte_i != NUL_BYTE);

  // Live after star closure; positions past the pattern end stay dead
  assign clos = (active_q & link_i.en) | link_i.spread;

  // Hand terms to the next cell
  assign link_o.en     = en;
  assign link_o.spread = clos & en & is_star;
  assign link_o.adv    = clos & en & ~is_star & (is_qmark | lit_hit);

  // This is the final position and it is live
  assign end_hit_o = clos & ~en;

  // Advance on a subject byte, drop back to start on the terminator
  always_comb begin
    active_d = active_q;
    if (restart_i) begin
      active_d = StartCell;
    end else if (step_i) begin
      active_d = (clos & en & is_star) | link_i.adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= StartCell;
    end else begin
      active_q <= active_d;
    end
  end

endmodule

[hdl/glob_wildcard_matcher_core.sv]
// Top level of the glob wildcard matcher: config registers, row of
// gwm_cell instances and the result register. Depends on gwm_pkg, gwm_cell.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata[7:0] subject_byte
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata[0] matched, [7:1] zero
//  cfg       in   cfg_valid_i/cfg_ready_o          cfg_addr_i index, cfg_data_i
//
// One subject byte is taken every cycle unless stalled; all positions
// update at once through the cell row, whose closure chain sets the
// clock path. The terminator's result appears the cycle after it is taken.
// Input stalls only while a result waits and m_axis_tready_i is low.
// Reset clears the pattern to empty and makes only the start position live.
module glob_wildcard_matcher_core #(
  parameter int unsigned MaxPatternBytes = gwm_pkg::MAX_PATTERN_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // subject bytes: [7:0] subject_byte
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [gwm_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // results: [0] matched, [7:1] zero
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [gwm_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  gwm_pkg::gwm_cfg_e               cfg_addr_i,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import gwm_pkg::*;

  localparam int unsigned NumCells = MaxPatternBytes + 1;

  logic [BYTE_W-1:0] pat_q [MaxPatternBytes];
  logic [LEN_W-1:0]  len_q;
  logic              fold_q;

  logic              out_valid_q, out_valid_d;
  logic              out_match_q, out_match_d;

  logic              cfg_we, in_acc, is_term, step, restart, hit;
  logic [BYTE_W-1:0] subj;
  gwm_link_t         link [NumCells+1];
  logic [NumCells-1:0] end_hit;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MaxPatternBytes); i++) begin
        pat_q[i] <= NUL_BYTE;
      end
      len_q  <= '0;
      fold_q <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr_i) inside
        CFG_PAT_WORD0, CFG_PAT_WORD1, CFG_PAT_WORD2, CFG_PAT_WORD3: begin
          for (int i = 0; i < int'(MaxPatternBytes); i++) begin
            if (cfg_addr_i[1:0] == 2'(i >> 3)) begin
              pat_q[i] <= cfg_data_i[(i & 7) * BYTE_W +: BYTE_W];
            end
          end
        end
        CFG_PAT_LEN:   len_q  <= cfg_data_i[LEN_W-1:0];
        CFG_CASE_FOLD: fold_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input handshake; hold input while an untaken result waits
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign subj     = s_axis_tdata_i[BYTE_W-1:0];
  assign is_term  = (subj == NUL_BYTE);
  assign step     = in_acc & ~is_term;
  assign restart  = in_acc & is_term;

  // Row of position cells; the start of the chain is always in use
  assign link[0] = '{en: 1'b1, spread: 1'b0, adv: 1'b0};

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    logic [BYTE_W-1:0] pb;
    logic              rng;
    if (g < MaxPatternBytes) begin : g_pat
      assign pb  = pat_q[g];
      assign rng = (len_q > LEN_W'(g));
    end else begin : g_end
      assign pb  = NUL_BYTE;
      assign rng = 1'b0;
    end
    gwm_cell #(
      .StartCell (g == 0)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .pat_byte_i (pb),
      .in_range_i (rng),
      .fold_i     (fold_q),
      .subj_i     (subj),
      .step_i     (step),
      .restart_i  (restart),
      .link_i     (link[g]),
      .link_o     (link[g+1]),
      .end_hit_o  (end_hit[g])
    );
  end

  assign hit = |end_hit;

  // Result register: load on terminator, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_match_d = out_match_q;
    if (restart) begin
      out_valid_d = 1'b1;
      out_match_d = hit;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_match_q <= out_match_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W-1){1'b0}}, out_match_q};

endmodule

[hdl/gwm_checker.sv]
// Port-level checks for glob_wildcard_matcher_core, attached by bind.
// Depends on gwm_pkg and the top level's port names.
module gwm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [gwm_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [gwm_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import gwm_pkg::*;

  logic term_acc;
  assign term_acc = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i == NUL_BYTE);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result item changed while stalled");

  // Input stalls only behind a waiting result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a waiting result");

  // A terminator item yields a result on the next cycle
  a_term_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_acc |=> m_axis_tvalid_o)
    else $error("terminator gave no result");

  // A result only follows a terminator item
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(term_acc))
    else $error("result without terminator");

  // Pad bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[M_TDATA_W-1:1] == '0))
    else $error("result pad bits not zero");

endmodule

bind glob_wildcard_matcher_core gwm_checker u_gwm_checker (.*);

[tb/sv/glob_wildcard_matcher_core_tb.sv]
// Self-checking testbench for glob_wildcard_matcher_core: programs glob patterns,
// streams subject strings and checks every match flag against a bit-parallel predictor.
// Depends on gwm_pkg and the matcher RTL; needs no files or arguments.
module glob_wildcard_matcher_core_tb;
  import gwm_pkg::*;

  localparam int unsigned HALF_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS   = 400;
  localparam int unsigned NUM_PHASES    = 3;
  localparam int unsigned POS_W         = MAX_PATTERN_BYTES + 1;
  // Bytes around the folding range plus plain letters of both cases
  localparam string       ALPHABET      = "aAbBzZ@[{c";

  localparam gwm_cfg_e WORD_REGS [4] = '{CFG_PAT_WORD0, CFG_PAT_WORD1,
                                         CFG_PAT_WORD2, CFG_PAT_WORD3};

  // Tracks programmed pattern and live positions, holds pending match flags
  class match_tracker;
    logic [CFG_DATA_W-1:0] pat_word [4];
    logic [LEN_W-1:0]      pat_len;
    logic                  fold_en;
    logic [POS_W-1:0]      live_pos;
    logic                  match_q [$];

    function new();
      for (int w = 0; w < 4; w++) pat_word[w] = '0;
      pat_len  = '0;
      fold_en  = 1'b0;
      live_pos = 1;
    endfunction

    function logic [BYTE_W-1:0] pat_byte(input int unsigned i);
      return pat_word[i / 8][8 * (i % 8) +: 8];
    endfunction

    // Saturate the length and cut the pattern at its first zero byte
    function int unsigned eff_len();
      int unsigned n;
      n = (pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : pat_len;
      for (int unsigned i = 0; i < n; i++) begin
        if (pat_byte(i) == NUL_BYTE) return i;
      end
      return n;
    endfunction

    function logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
      if (fold_en && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
      return c;
    endfunction

    // Let a live star also enable the position after it
    function logic [POS_W-1:0] close_stars(input logic [POS_W-1:0] v, input int unsigned n);
      logic [POS_W-1:0] r;
      r = v & ({POS_W{1'b1}} >> (MAX_PATTERN_BYTES - n));
      for (int unsigned i = 0; i < n; i++) begin
        if (r[i] && pat_byte(i) == STAR_BYTE) r[i + 1] = 1'b1;
      end
      return r;
    endfunction

    function void note_config(input gwm_cfg_e idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PAT_WORD0: pat_word[0] = data;
        CFG_PAT_WORD1: pat_word[1] = data;
        CFG_PAT_WORD2: pat_word[2] = data;
        CFG_PAT_WORD3: pat_word[3] = data;
        CFG_PAT_LEN:   pat_len = data[LEN_W-1:0];
        CFG_CASE_FOLD: fold_en = data[0];
        default: ;
      endcase
    endfunction

    // Advance live positions by one subject byte; a terminator yields a flag
    function void note_byte(input logic [BYTE_W-1:0] b);
      int unsigned      n;
      logic [POS_W-1:0] v;
      logic [POS_W-1:0] nv;
      logic [BYTE_W-1:0] p;
      n = eff_len();
      v = close_stars(live_pos, n);
      if (b == NUL_BYTE) begin
        match_q.push_back(v[n]);
        live_pos = 1;
      end else begin
        nv = '0;
        for (int unsigned i = 0; i < n; i++) begin
          if (v[i]) begin
            p = pat_byte(i);
            if (p == STAR_BYTE) nv[i] = 1'b1;
            else if (p == QMARK_BYTE || to_lower(p) == to_lower(b)) nv[i + 1] = 1'b1;
          end
        end
        live_pos = nv;
      end
    endfunction

    function int unsigned pending();
      return match_q.size();
    endfunction

    // Compare one result with the oldest flag; empty string means it agrees
    function string check_result(input logic [M_TDATA_W-1:0] tdata);
      logic want;
      if (match_q.size() == 0) return $sformatf("result 0x%02h with no match pending", tdata);
      want = match_q.pop_front();
      if (tdata[0] !== want) return $sformatf("matched %0b, predicted %0b", tdata[0], want);
      if (tdata[M_TDATA_W-1:1] !== '0)
        return $sformatf("padding bits 0x%02h not zero", tdata[M_TDATA_W-1:1]);
      return "";
    endfunction
  endclass

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [S_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  gwm_cfg_e              cfg_addr        = CFG_PAT_WORD0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  match_tracker          tracker = new();
  logic [BYTE_W-1:0]     pat_buf [MAX_PATTERN_BYTES];
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  int unsigned           items_sent     = 0;
  int unsigned           mismatch_count = 0;
  int unsigned           cycle_count    = 0;

  glob_wildcard_matcher_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Abort a hung run
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Check accepted results and stall the result side at random
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        msg = tracker.check_result(m_axis_tdata_o);
        if (msg != "") report_mismatch(msg);
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_cfg(input gwm_cfg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr    <= idx;
    cfg_data    <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.note_config(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one subject byte after a random gap and hold it until taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    tracker.note_byte(b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(NUL_BYTE);
  endtask

  // Stop the subject stream and wait until the block has gone idle
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void set_pattern_text(input string s);
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) pat_buf[i] = (i < s.len()) ? s[i] : NUL_BYTE;
  endfunction

  // Write all pattern words from pat_buf, then length and folding
  task automatic program_pattern(input logic [LEN_W-1:0] len_value, input logic fold);
    logic [CFG_DATA_W-1:0] word;
    for (int w = 0; w < 4; w++) begin
      for (int k = 0; k < 8; k++) word[8*k +: 8] = pat_buf[8*w + k];
      write_cfg(WORD_REGS[w], word);
    end
    write_cfg(CFG_PAT_LEN, CFG_DATA_W'(len_value));
    write_cfg(CFG_CASE_FOLD, CFG_DATA_W'(fold));
  endtask

  function automatic logic [BYTE_W-1:0] pick_letter();
    return ALPHABET[$urandom_range(ALPHABET.len() - 1)];
  endfunction

  function automatic logic [BYTE_W-1:0] pick_pattern_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return STAR_BYTE;
    if (r < 35) return QMARK_BYTE;
    if (r < 85) return pick_letter();
    if (r < 97) return BYTE_W'($urandom_range(255, 1));
    return NUL_BYTE;
  endfunction

  // Subject bytes are never zero; wildcard bytes here are plain data
  function automatic logic [BYTE_W-1:0] pick_subject_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return pick_letter();
    if (r < 68) return STAR_BYTE;
    if (r < 75) return QMARK_BYTE;
    return BYTE_W'($urandom_range(255, 1));
  endfunction

  function automatic logic [BYTE_W-1:0] flip_case(input logic [BYTE_W-1:0] c);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return c ^ CASE_BIT;
    return c;
  endfunction

  task automatic program_random_pattern();
    int unsigned r;
    int unsigned n;
    logic        raw;
    r = $urandom_range(99);
    if (r < 70) n = $urandom_range(8);
    else if (r < 95) n = $urandom_range(32, 9);
    else n = $urandom_range(63, 33);
    raw = ($urandom_range(9) == 0);
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      pat_buf[i] = raw ? BYTE_W'($urandom_range(255)) : pick_pattern_byte();
    end
    if ($urandom_range(19) == 0) begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) pat_buf[i] = 8'hFF;
    end
    program_pattern(LEN_W'(n), 1'($urandom_range(1)));
  endtask

  // Mostly strings built from the pattern, some mutated, the rest noise
  task automatic send_random_subject();
    logic [BYTE_W-1:0] subj [$];
    logic [BYTE_W-1:0] p;
    int unsigned       n;
    n = tracker.eff_len();
    if ($urandom_range(99) < 70) begin
      for (int unsigned i = 0; i < n; i++) begin
        p = tracker.pat_byte(i);
        if (p == STAR_BYTE) begin
          repeat ($urandom_range(3)) subj.push_back(pick_subject_byte());
        end else if (p == QMARK_BYTE) begin
          subj.push_back(pick_subject_byte());
        end else begin
          subj.push_back((tracker.fold_en && $urandom_range(1)) ? flip_case(p) : p);
        end
      end
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(2))
          0: if (subj.size() > 0) subj[$urandom_range(subj.size() - 1)] = pick_subject_byte();
          1: if (subj.size() > 0) void'(subj.pop_back());
          default: subj.push_back(pick_subject_byte());
        endcase
      end
    end else begin
      repeat ($urandom_range(10)) subj.push_back(pick_subject_byte());
    end
    foreach (subj[i]) send_byte(subj[i]);
    send_byte(NUL_BYTE);
  endtask

  task automatic run_directed();
    // Empty pattern after reset: only the empty subject matches
    send_byte(NUL_BYTE);
    send_byte(8'h01);
    send_byte(NUL_BYTE);
    // Wildcard bytes in the subject are ordinary data
    drain_results();
    set_pattern_text("a?b");
    program_pattern(LEN_W'(3), 1'b0);
    send_text("a*b");
    // Folding covers letters only, not the bytes next to them
    drain_results();
    set_pattern_text("Ab[");
    program_pattern(LEN_W'(3), 1'b1);
    send_text("aB[");
    send_text("aB{");
    // Zero byte cuts the pattern; oversized length saturates
    drain_results();
    set_pattern_text("ab?cd");
    pat_buf[2] = NUL_BYTE;
    program_pattern(LEN_W'(63), 1'b0);
    send_text("ab");
    // Full-length pattern of stars against the top byte value
    drain_results();
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) pat_buf[i] = STAR_BYTE;
    program_pattern(LEN_W'(MAX_PATTERN_BYTES), 1'b0);
    send_byte(8'hFF);
    send_byte(NUL_BYTE);
    // Swap the pattern halfway through a string; live positions carry over
    drain_results();
    set_pattern_text("ab");
    program_pattern(LEN_W'(2), 1'b0);
    send_byte("a");
    drain_results();
    set_pattern_text("xy");
    program_pattern(LEN_W'(2), 1'b0);
    send_byte("y");
    send_byte(NUL_BYTE);
  endtask

  // Reset, directed checks, then random phases with shifting back-pressure
  initial begin
    int unsigned target;
    send_idle_pct = 35;
    recv_idle_pct = 86;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        drain_results();
        program_random_pattern();
        repeat ($urandom_range(6, 2)) send_random_subject();
      end
    end
    drain_results();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
